@@ src/afad_pkg.sv @@
// Package for the ARM/Thumb fault address decoder: instruction form codes,
// match constants and the Thumb form classifier shared by the top level and the
// address calculator. It has no dependencies.
package afad_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned REG_IDX_W = 4;
   localparam int unsigned THUMB_W = 16;

   // Register numbers with a fixed role.
   localparam logic [REG_IDX_W-1:0] REG_SP = 4'd13;
   localparam logic [REG_IDX_W-1:0] REG_PC = 4'd15;

   // ARM match masks and patterns.
   localparam logic [WORD_W-1:0] ARM_SWP_MASK    = 32'h0FB0_0FF0;
   localparam logic [WORD_W-1:0] ARM_SWP_PAT     = 32'h0100_0090;
   localparam logic [WORD_W-1:0] ARM_SINGLE_MASK = 32'h0C00_0000;
   localparam logic [WORD_W-1:0] ARM_SINGLE_PAT  = 32'h0400_0000;
   localparam logic [WORD_W-1:0] ARM_HREG_MASK   = 32'h0E00_0F90;
   localparam logic [WORD_W-1:0] ARM_HREG_PAT    = 32'h0000_0090;
   localparam logic [WORD_W-1:0] ARM_HIMM_MASK   = 32'h0E40_0090;
   localparam logic [WORD_W-1:0] ARM_HIMM_PAT    = 32'h0040_0090;
   localparam logic [WORD_W-1:0] ARM_MULTI_MASK  = 32'h0E00_0000;
   localparam logic [WORD_W-1:0] ARM_MULTI_PAT   = 32'h0800_0000;

   // Thumb match masks and patterns.
   localparam logic [THUMB_W-1:0] TH_MASK5     = 16'hF800;
   localparam logic [THUMB_W-1:0] TH_MASK4     = 16'hF000;
   localparam logic [THUMB_W-1:0] TH_MASK3     = 16'hE000;
   localparam logic [THUMB_W-1:0] TH_PUSH_MASK = 16'hF600;
   localparam logic [THUMB_W-1:0] TH_PC_PAT    = 16'h4800;
   localparam logic [THUMB_W-1:0] TH_REG_PAT   = 16'h5000;
   localparam logic [THUMB_W-1:0] TH_IMM_PAT   = 16'h6000;
   localparam logic [THUMB_W-1:0] TH_HALF_PAT  = 16'h8000;
   localparam logic [THUMB_W-1:0] TH_SP_PAT    = 16'h9000;
   localparam logic [THUMB_W-1:0] TH_PUSH_PAT  = 16'hB400;
   localparam logic [THUMB_W-1:0] TH_MULTI_PAT = 16'hC000;

   typedef enum logic [2:0] {
      TF_PC_LOAD,
      TF_REG_OFS,
      TF_IMM_WB,
      TF_IMM_HALF,
      TF_SP_REL,
      TF_PUSH_POP,
      TF_MULTI,
      TF_NONE
   } thumb_form_type;

   typedef enum logic [2:0] {
      AF_SWP,
      AF_SINGLE,
      AF_HALF,
      AF_MULTI,
      AF_NONE
   } arm_form_type;

   typedef struct packed {
      logic [WORD_W-1:0] addr;
      logic              recognized;
   } afad_result_type;

   // Classify a Thumb halfword; earlier patterns take precedence.
   function automatic thumb_form_type thumb_form(input logic [THUMB_W-1:0] op);
      thumb_form_type f;
      priority if ((op & TH_MASK5) == TH_PC_PAT)        f = TF_PC_LOAD;
      else if ((op & TH_MASK4) == TH_REG_PAT)           f = TF_REG_OFS;
      else if ((op & TH_MASK3) == TH_IMM_PAT)           f = TF_IMM_WB;
      else if ((op & TH_MASK4) == TH_HALF_PAT)          f = TF_IMM_HALF;
      else if ((op & TH_MASK4) == TH_SP_PAT)            f = TF_SP_REL;
      else if ((op & TH_PUSH_MASK) == TH_PUSH_PAT)      f = TF_PUSH_POP;
      else if ((op & TH_MASK4) == TH_MULTI_PAT)         f = TF_MULTI;
      else                                              f = TF_NONE;
      return f;
   endfunction

endpackage

@@ src/afad_if.sv @@
// Handshake interfaces for the request and response channels of the fault
// address decoder. Depends on afad_pkg for the field widths.
interface afad_req_if import afad_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 action;
   logic [REG_IDX_W-1:0] reg_index;
   logic [WORD_W-1:0]    reg_value;
   logic [WORD_W-1:0]    instr_word;
   logic                 thumb_mode;

   modport source (output valid, action, reg_index, reg_value, instr_word, thumb_mode,
                   input ready);
   modport sink   (input valid, action, reg_index, reg_value, instr_word, thumb_mode,
                   output ready);
endinterface

interface afad_rsp_if import afad_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] fault_address;
   logic              recognized;

   modport source (output valid, fault_address, recognized, input ready);
   modport sink   (input valid, fault_address, recognized, output ready);
endinterface

@@ src/arm_thumb_fault_address_decoder.sv @@
// Top level of the ARM/Thumb fault address decoder. Depends on afad_pkg,
// the channel interfaces, afad_regfile and afad_calc.
//
// The block keeps sixteen saved 32-bit registers, all zero after reset. A
// request transaction with action 0 writes one of them and produces no
// response. A request transaction with action 1 presents a faulting ARM or
// Thumb instruction and produces exactly one response transaction carrying
// the data address the instruction accesses, or address zero with the
// recognized flag low when the word is not a supported load/store form.
// The block accepts one transaction per clock unless its decode stage and the
// response register are both full and the consumer holds off. Each decode
// passes the registered read of the two source registers from the register
// file, then the decode, shift and add into the response register. A request
// stage in front of the response register lets a new transaction enter while
// a finished response waits for the consumer.
module arm_thumb_fault_address_decoder import afad_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   afad_req_if.sink  req_ch,
   afad_rsp_if.source rsp_ch
);

   logic                 accept;
   logic                 wr_en;
   logic                 rd_en;
   logic [REG_IDX_W-1:0] rd_idx_a;
   logic [REG_IDX_W-1:0] rd_idx_b;
   logic [WORD_W-1:0]    rd_data_a;
   logic [WORD_W-1:0]    rd_data_b;
   thumb_form_type       req_tform;

   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   logic [WORD_W-1:0]    s1_instr_ff;
   logic                 s1_thumb_ff;
   logic                 s1_adv;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [WORD_W-1:0]    rsp_addr_ff;
   logic                 rsp_recog_ff;
   afad_result_type      calc_result;

   // The decode stage advances whenever the response register is free or is
   // being emptied this cycle.
   assign s1_adv       = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign wr_en        = accept && !req_ch.action;
   assign rd_en        = accept && req_ch.action;

   // Pick the base and offset register numbers straight from the incoming
   // word so that the register file read happens at acceptance.
   assign req_tform = thumb_form(req_ch.instr_word[THUMB_W-1:0]);

   always_comb begin
      if (req_ch.thumb_mode) begin
         rd_idx_b = {1'b0, req_ch.instr_word[8:6]};
         unique case (req_tform)
            TF_PC_LOAD:             rd_idx_a = REG_PC;
            TF_SP_REL, TF_PUSH_POP: rd_idx_a = REG_SP;
            TF_MULTI:               rd_idx_a = {1'b0, req_ch.instr_word[10:8]};
            default:                rd_idx_a = {1'b0, req_ch.instr_word[5:3]};
         endcase
      end else begin
         rd_idx_a = req_ch.instr_word[19:16];
         rd_idx_b = req_ch.instr_word[3:0];
      end
   end

   afad_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_en),
      .wr_idx    (req_ch.reg_index),
      .wr_data   (req_ch.reg_value),
      .rd_en     (rd_en),
      .rd_idx_a  (rd_idx_a),
      .rd_idx_b  (rd_idx_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // Decode stage: holds the instruction while its register values sit in
   // the register file's read registers.
   always_comb begin
      if (rd_en) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_instr_ff <= req_ch.instr_word;
         s1_thumb_ff <= req_ch.thumb_mode;
      end
   end

   afad_calc u_calc (
      .instr_word  (s1_instr_ff),
      .thumb_mode  (s1_thumb_ff),
      .base_value  (rd_data_a),
      .index_value (rd_data_b),
      .result      (calc_result)
   );

   // Response register.
   always_comb begin
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_addr_ff  <= calc_result.addr;
         rsp_recog_ff <= calc_result.recognized;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.fault_address = rsp_addr_ff;
   assign rsp_ch.recognized    = rsp_recog_ff;

endmodule

@@ src/afad_regfile.sv @@
// Sixteen-entry saved register file with one write port and two registered
// read ports. Entries never written read as zero. Depends on afad_pkg.
module afad_regfile import afad_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [REG_IDX_W-1:0] wr_idx,
   input  logic [WORD_W-1:0]    wr_data,
   input  logic                 rd_en,
   input  logic [REG_IDX_W-1:0] rd_idx_a,
   input  logic [REG_IDX_W-1:0] rd_idx_b,
   output logic [WORD_W-1:0]    rd_data_a,
   output logic [WORD_W-1:0]    rd_data_b
);

   localparam int unsigned DEPTH = 2 ** REG_IDX_W;

   logic [WORD_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [DEPTH-1:0]  valid_in;
   logic [WORD_W-1:0] data_a_ff;
   logic [WORD_W-1:0] data_b_ff;
   logic              vld_a_ff;
   logic              vld_b_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   // The valid flag is read together with the data so that an entry still at
   // its reset value shows zero.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_a_ff <= mem[rd_idx_a];
         data_b_ff <= mem[rd_idx_b];
         vld_a_ff  <= valid_ff[rd_idx_a];
         vld_b_ff  <= valid_ff[rd_idx_b];
      end
   end

   assign rd_data_a = vld_a_ff ? data_a_ff : '0;
   assign rd_data_b = vld_b_ff ? data_b_ff : '0;

endmodule

@@ src/afad_calc.sv @@
// Combinational address calculator: decodes an ARM or Thumb load/store word
// and forms the data address from two register values. Depends on afad_pkg.
module afad_calc import afad_pkg::*; (
   input  logic [WORD_W-1:0] instr_word,
   input  logic              thumb_mode,
   input  logic [WORD_W-1:0] base_value,
   input  logic [WORD_W-1:0] index_value,
   output afad_result_type   result
);

   logic [THUMB_W-1:0]    op;
   logic [4:0]            imm5;
   thumb_form_type        tform;
   arm_form_type          aform;
   logic [WORD_W-1:0]     thumb_addr;
   logic                  thumb_ok;
   logic [WORD_W-1:0]     arm_addr;
   logic                  arm_ok;
   logic [WORD_W-1:0]     arm_off;
   logic [WORD_W-1:0]     shifted;
   logic [2*WORD_W-1:0]   rot_wide;
   logic [4:0]            shamt;
   logic [WORD_W-1:0]     indexed;

   assign op    = instr_word[THUMB_W-1:0];
   assign imm5  = op[10:6];
   assign tform = thumb_form(op);

   always_comb begin
      thumb_ok = 1'b1;
      unique case (tform)
         TF_PC_LOAD:  thumb_addr = base_value + {22'd0, op[7:0], 2'b00};
         TF_REG_OFS:  thumb_addr = base_value + index_value;
         TF_IMM_WB:   thumb_addr = op[12] ? base_value + {27'd0, imm5}
                                          : base_value + {25'd0, imm5, 2'b00};
         TF_IMM_HALF: thumb_addr = base_value + {26'd0, imm5, 1'b0};
         TF_SP_REL:   thumb_addr = base_value + {22'd0, op[7:0], 2'b00};
         TF_PUSH_POP: thumb_addr = base_value;
         TF_MULTI:    thumb_addr = base_value;
         default: begin
            thumb_addr = '0;
            thumb_ok   = 1'b0;
         end
      endcase
   end

   always_comb begin
      priority if ((instr_word & ARM_SWP_MASK) == ARM_SWP_PAT)          aform = AF_SWP;
      else if ((instr_word & ARM_SINGLE_MASK) == ARM_SINGLE_PAT)        aform = AF_SINGLE;
      else if ((instr_word & ARM_HREG_MASK) == ARM_HREG_PAT ||
               (instr_word & ARM_HIMM_MASK) == ARM_HIMM_PAT)            aform = AF_HALF;
      else if ((instr_word & ARM_MULTI_MASK) == ARM_MULTI_PAT)          aform = AF_MULTI;
      else                                                              aform = AF_NONE;
   end

   // Immediate shift of the offset register. A zero amount means LSR #32 and
   // ASR #32 for the right shifts; rotate by zero passes the value through.
   assign shamt    = instr_word[11:7];
   assign rot_wide = {index_value, index_value} >> shamt;

   always_comb begin
      unique case (instr_word[6:5])
         2'd0: shifted = index_value << shamt;
         2'd1: shifted = (shamt == 5'd0) ? '0 : index_value >> shamt;
         2'd2: shifted = (shamt == 5'd0) ? {WORD_W{index_value[WORD_W-1]}}
                                         : WORD_W'($signed(index_value) >>> shamt);
         default: shifted = rot_wide[WORD_W-1:0];
      endcase
   end

   always_comb begin
      if (aform == AF_SINGLE) begin
         arm_off = instr_word[25] ? shifted : {20'd0, instr_word[11:0]};
      end else begin
         arm_off = instr_word[22] ? {24'd0, instr_word[11:8], instr_word[3:0]} : index_value;
      end
   end

   // Post-indexed forms use the base itself; pre-indexed add or subtract by U.
   assign indexed = !instr_word[24] ? base_value
                  : instr_word[23] ? base_value + arm_off
                  : base_value - arm_off;

   always_comb begin
      arm_ok   = 1'b1;
      arm_addr = '0;
      unique case (aform)
         AF_SWP:   arm_addr = base_value;
         AF_SINGLE: begin
            if (instr_word[25] && instr_word[4]) begin
               arm_ok = 1'b0;
            end else begin
               arm_addr = indexed;
            end
         end
         AF_HALF: begin
            if (instr_word[6:5] == 2'b00) begin
               arm_ok = 1'b0;
            end else begin
               arm_addr = indexed;
            end
         end
         AF_MULTI: arm_addr = base_value;
         default:  arm_ok = 1'b0;
      endcase
   end

   assign result.addr       = thumb_mode ? thumb_addr : arm_addr;
   assign result.recognized = thumb_mode ? thumb_ok : arm_ok;

endmodule

@@ src/afad_checker.sv @@
// Port-level assertions for the fault address decoder and the bind that
// attaches them to the top level. Depends on afad_pkg and the top level.
module afad_checker import afad_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              req_action,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [WORD_W-1:0] rsp_fault_address,
   input logic              rsp_recognized
);

   // A response held back by the consumer keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fault_address)
                                 && $stable(rsp_recognized))
      else $error("stalled response changed");

   // An unrecognized word always reports address zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_recognized |-> rsp_fault_address == '0)
      else $error("unrecognized response with nonzero address");

   // With the response register empty the block always takes a request.
   assert property (@(posedge clock)
      !rsp_valid |-> req_ready)
      else $error("request refused while response register is empty");

   // A response that appears after an idle output comes from an accepted decode request
   // that passed through the decode stage into the response register.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid) |-> $past(req_valid && req_ready && req_action, 2))
      else $error("response without a matching decode request");

endmodule

bind arm_thumb_fault_address_decoder afad_checker u_afad_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .req_action        (req_ch.action),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_fault_address (rsp_ch.fault_address),
   .rsp_recognized    (rsp_ch.recognized)
);

@@ bench/arm_thumb_fault_address_decoder_tb.sv @@
// Self-checking testbench for arm_thumb_fault_address_decoder: a directed table followed by
// constrained-random register loads and ARM/Thumb decodes, each checked against a local
// predictor. Depends on afad_pkg, the afad_req_if/afad_rsp_if interfaces and the RTL.
`timescale 1ns / 100ps

module arm_thumb_fault_address_decoder_tb;
   import afad_pkg::*;

   localparam int CLK_PERIOD   = 8;
   localparam int RESET_CYCLES = 3;
   // The response register sits behind the register file read and the decode stage, so a
   // short drain after the last expected response is enough to catch anything unexpected.
   localparam int DRAIN_CYCLES = 12;
   localparam int PHASE_ITEMS  = 431;

   // Request action and instruction set codes.
   localparam logic ACT_SET_REG = 1'b0;
   localparam logic ACT_DECODE  = 1'b1;
   localparam logic MODE_ARM    = 1'b0;
   localparam logic MODE_THUMB  = 1'b1;

   // Barrel shifter kinds in bits 6:5 of a scaled register offset.
   typedef enum logic [1:0] {SH_LSL, SH_LSR, SH_ASR, SH_ROR} shift_kind_type;

   // ARM encoding masks and patterns, plus the control bits of the indexed forms.
   localparam logic [31:0] A_SWP_MASK    = 32'h0FB0_0FF0;
   localparam logic [31:0] A_SWP_PAT     = 32'h0100_0090;
   localparam logic [31:0] A_SINGLE_MASK = 32'h0C00_0000;
   localparam logic [31:0] A_SINGLE_PAT  = 32'h0400_0000;
   localparam logic [31:0] A_HREG_MASK   = 32'h0E00_0F90;
   localparam logic [31:0] A_HREG_PAT    = 32'h0000_0090;
   localparam logic [31:0] A_HIMM_MASK   = 32'h0E40_0090;
   localparam logic [31:0] A_HIMM_PAT    = 32'h0040_0090;
   localparam logic [31:0] A_BLOCK_MASK  = 32'h0E00_0000;
   localparam logic [31:0] A_BLOCK_PAT   = 32'h0800_0000;
   localparam int BIT_REG_OFS  = 25;   // single transfer: offset is a shifted register
   localparam int BIT_PRE      = 24;   // pre-indexed when set
   localparam int BIT_UP       = 23;   // add the offset when set
   localparam int BIT_HALF_IMM = 22;   // halfword transfer: split immediate offset
   localparam int BIT_SH_BYREG = 4;    // shift by register, undefined for LDR/STR

   // Thumb encoding masks and patterns.
   localparam logic [15:0] T_MASK5     = 16'hF800;
   localparam logic [15:0] T_MASK4     = 16'hF000;
   localparam logic [15:0] T_MASK3     = 16'hE000;
   localparam logic [15:0] T_PUSH_MASK = 16'hF600;
   localparam logic [15:0] T_PC_PAT    = 16'h4800;
   localparam logic [15:0] T_REG_PAT   = 16'h5000;
   localparam logic [15:0] T_IMM_PAT   = 16'h6000;
   localparam logic [15:0] T_HALF_PAT  = 16'h8000;
   localparam logic [15:0] T_SP_PAT    = 16'h9000;
   localparam logic [15:0] T_PUSH_PAT  = 16'hB400;
   localparam logic [15:0] T_MULTI_PAT = 16'hC000;
   localparam int T_BIT_BYTE = 12;      // word/byte immediate form: byte access when set

   logic clock = 1'b0;
   logic reset;

   afad_req_if req_ch ();
   afad_rsp_if rsp_ch ();

   arm_thumb_fault_address_decoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Shadow copy of the saved registers, kept in transaction order by the monitor.
   logic [31:0] saved_regs [16];

   // Addresses still owed by the block, oldest first.
   afad_result_type expected_access [$];

   // A directed row may carry a hand-written expectation; it travels beside the request
   // so the monitor can pick it up at the accepting edge.
   logic            pin_en;
   afad_result_type pin_value;

   // Idle percentages for the current phase.
   int send_idle_pct;
   int recv_stall_pct;

   int fail_count;
   int n_reg_loads;
   int n_decodes;
   int n_thumb;
   int n_checked;
   int n_recognized;

   // ---------------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------------

   // Scaled register offset. An amount of zero encodes LSR #32 and ASR #32, and for ROR
   // it leaves the operand alone because no carry is available for RRX.
   function automatic logic [31:0] shift_operand(input logic [31:0] value,
                                                 input shift_kind_type kind,
                                                 input logic [4:0] amount);
      logic [63:0] doubled;
      doubled = {value, value};
      case (kind)
         SH_LSL: return value << amount;
         SH_LSR: return (amount == 5'd0) ? 32'd0 : value >> amount;
         SH_ASR: return (amount == 5'd0) ? {32{value[31]}} : 32'($signed(value) >>> amount);
         default: return doubled[31:0] >> amount | doubled[63:32] << (6'd32 - amount);
      endcase
   endfunction

   // Post-indexed transfers access the base itself; pre-indexed ones apply the offset
   // in the direction the U bit gives.
   function automatic logic [31:0] indexed_address(input logic [31:0] word,
                                                   input logic [31:0] base,
                                                   input logic [31:0] offset);
      if (!word[BIT_PRE])
         return base;
      return word[BIT_UP] ? base + offset : base - offset;
   endfunction

   function automatic afad_result_type predict_access(input logic [31:0] word,
                                                      input logic thumb);
      afad_result_type res;
      logic [15:0]     op;
      logic [31:0]     base;
      logic [31:0]     offset;
      logic [31:0]     imm5;
      res.addr = '0;
      res.recognized = 1'b1;
      op = word[15:0];
      imm5 = 32'(op[10:6]);
      if (thumb == MODE_THUMB) begin
         if ((op & T_MASK5) == T_PC_PAT)
            res.addr = saved_regs[REG_PC] + (32'(op[7:0]) << 2);
         else if ((op & T_MASK4) == T_REG_PAT)
            res.addr = saved_regs[{1'b0, op[5:3]}] + saved_regs[{1'b0, op[8:6]}];
         else if ((op & T_MASK3) == T_IMM_PAT)
            res.addr = saved_regs[{1'b0, op[5:3]}] + (op[T_BIT_BYTE] ? imm5 : imm5 << 2);
         else if ((op & T_MASK4) == T_HALF_PAT)
            res.addr = saved_regs[{1'b0, op[5:3]}] + (imm5 << 1);
         else if ((op & T_MASK4) == T_SP_PAT)
            res.addr = saved_regs[REG_SP] + (32'(op[7:0]) << 2);
         else if ((op & T_PUSH_MASK) == T_PUSH_PAT)
            res.addr = saved_regs[REG_SP];
         else if ((op & T_MASK4) == T_MULTI_PAT)
            res.addr = saved_regs[{1'b0, op[10:8]}];
         else
            res.recognized = 1'b0;
      end else begin
         base = saved_regs[word[19:16]];
         if ((word & A_SWP_MASK) == A_SWP_PAT) begin
            res.addr = base;
         end else if ((word & A_SINGLE_MASK) == A_SINGLE_PAT) begin
            if (word[BIT_REG_OFS] && word[BIT_SH_BYREG]) begin
               res.recognized = 1'b0;
            end else begin
               if (word[BIT_REG_OFS])
                  offset = shift_operand(saved_regs[word[3:0]], shift_kind_type'(word[6:5]),
                                         word[11:7]);
               else
                  offset = 32'(word[11:0]);
               res.addr = indexed_address(word, base, offset);
            end
         end else if ((word & A_HREG_MASK) == A_HREG_PAT ||
                      (word & A_HIMM_MASK) == A_HIMM_PAT) begin
            // Bits 6:5 both clear is the multiply space, not a halfword transfer.
            if (word[6:5] == 2'b00) begin
               res.recognized = 1'b0;
            end else begin
               if (word[BIT_HALF_IMM])
                  offset = 32'({word[11:8], word[3:0]});
               else
                  offset = saved_regs[word[3:0]];
               res.addr = indexed_address(word, base, offset);
            end
         end else if ((word & A_BLOCK_MASK) == A_BLOCK_PAT) begin
            res.addr = base;
         end else begin
            res.recognized = 1'b0;
         end
      end
      if (!res.recognized)
         res.addr = '0;
      return res;
   endfunction

   // ---------------------------------------------------------------------------------
   // Monitor and scoreboard. Inputs change at the falling edge, so everything sampled
   // here at the rising edge is stable.
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         foreach (saved_regs[i])
            saved_regs[i] = '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.action == ACT_SET_REG) begin
               saved_regs[req_ch.reg_index] = req_ch.reg_value;
               n_reg_loads++;
            end else begin
               n_decodes++;
               if (req_ch.thumb_mode == MODE_THUMB)
                  n_thumb++;
               if (pin_en)
                  expected_access.push_back(pin_value);
               else
                  expected_access.push_back(predict_access(req_ch.instr_word,
                                                           req_ch.thumb_mode));
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_access.size() == 0) begin
               $error("unexpected response: fault_address %h recognized %b",
                      rsp_ch.fault_address, rsp_ch.recognized);
               fail_count++;
            end else begin
               afad_result_type want;
               want = expected_access.pop_front();
               n_checked++;
               if (want.recognized)
                  n_recognized++;
               if (rsp_ch.fault_address !== want.addr) begin
                  $error("fault_address: expected %h, actual %h", want.addr,
                         rsp_ch.fault_address);
                  fail_count++;
               end
               if (rsp_ch.recognized !== want.recognized) begin
                  $error("recognized: expected %b, actual %b", want.recognized,
                         rsp_ch.recognized);
                  fail_count++;
               end
            end
         end
      end
   end

   // The consumer stalls at random with the percentage of the current phase.
   always @(negedge clock)
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

   // ---------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------

   // Drive one request transaction and hold it until the block takes it. Idle cycles
   // in front of it follow the sender percentage of the current phase.
   task automatic send_request(input logic act, input logic [3:0] reg_sel,
                               input logic [31:0] reg_data, input logic [31:0] word,
                               input logic thumb, input logic pinned,
                               input afad_result_type pinned_value);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid      <= 1'b1;
      req_ch.action     <= act;
      req_ch.reg_index  <= reg_sel;
      req_ch.reg_value  <= reg_data;
      req_ch.instr_word <= word;
      req_ch.thumb_mode <= thumb;
      pin_en            <= pinned;
      pin_value         <= pinned_value;
      forever begin
         @(posedge clock);
         if (req_ch.ready)
            break;
      end
   endtask

   // Mostly well-formed ARM transfers with random fields, some arbitrary words.
   function automatic logic [31:0] make_arm_word();
      logic [31:0] word;
      arm_form_type form;
      word = $urandom();
      form = arm_form_type'(3'($urandom_range(4)));
      case (form)
         AF_SWP: word = (word & ~A_SWP_MASK) | A_SWP_PAT;
         AF_SINGLE: begin
            word = (word & ~A_SINGLE_MASK) | A_SINGLE_PAT;
            // Keep the undefined shift-by-register form rare, and favor the zero
            // shift amount that changes the meaning of LSR, ASR and ROR.
            if (word[BIT_REG_OFS] && $urandom_range(7) != 0)
               word[BIT_SH_BYREG] = 1'b0;
            if ($urandom_range(3) == 0)
               word[11:7] = 5'd0;
         end
         AF_HALF: begin
            if (word[BIT_HALF_IMM])
               word = (word & ~A_HIMM_MASK) | A_HIMM_PAT;
            else
               word = (word & ~A_HREG_MASK) | A_HREG_PAT;
         end
         AF_MULTI: word = (word & ~A_BLOCK_MASK) | A_BLOCK_PAT;
         default: ;
      endcase
      return word;
   endfunction

   // Thumb forms keep random upper bits, which the block must ignore.
   function automatic logic [31:0] make_thumb_word();
      logic [31:0] word;
      thumb_form_type form;
      word = $urandom();
      form = thumb_form_type'(3'($urandom_range(7)));
      case (form)
         TF_PC_LOAD:  word[15:0] = (word[15:0] & ~T_MASK5) | T_PC_PAT;
         TF_REG_OFS:  word[15:0] = (word[15:0] & ~T_MASK4) | T_REG_PAT;
         TF_IMM_WB:   word[15:0] = (word[15:0] & ~T_MASK3) | T_IMM_PAT;
         TF_IMM_HALF: word[15:0] = (word[15:0] & ~T_MASK4) | T_HALF_PAT;
         TF_SP_REL:   word[15:0] = (word[15:0] & ~T_MASK4) | T_SP_PAT;
         TF_PUSH_POP: word[15:0] = (word[15:0] & ~T_PUSH_MASK) | T_PUSH_PAT;
         TF_MULTI:    word[15:0] = (word[15:0] & ~T_MASK4) | T_MULTI_PAT;
         default: ;
      endcase
      return word;
   endfunction

   // Register values lean toward the boundaries so that the address adds and subtracts
   // wrap often.
   function automatic logic [31:0] make_reg_value();
      case ($urandom_range(7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   task automatic run_random(input int count);
      afad_result_type none;
      logic thumb;
      none = '0;
      for (int i = 0; i < count; i++) begin
         thumb = 1'($urandom_range(1));
         // About one transaction in five reloads a saved register; the rest decode.
         // Fields a transaction does not use still carry random values.
         if ($urandom_range(99) < 20)
            send_request(ACT_SET_REG, 4'($urandom_range(15)), make_reg_value(),
                         $urandom(), thumb, 1'b0, none);
         else
            send_request(ACT_DECODE, 4'($urandom_range(15)), $urandom(),
                         thumb ? make_thumb_word() : make_arm_word(), thumb, 1'b0, none);
      end
   endtask

   // Directed table. The first rows run on the all-zero register file or are encodings
   // that are never recognized, so their response is written out here; the rest go
   // through the predictor.
   typedef struct packed {
      logic        action;
      logic [3:0]  reg_sel;
      logic [31:0] reg_data;
      logic [31:0] word;
      logic        thumb;
      logic        pinned;
      logic [31:0] pin_addr;
      logic        pin_rec;
   } directed_row_type;

   localparam int N_DIRECTED = 27;

   directed_row_type directed_rows [N_DIRECTED] = '{
      // Zero registers after reset: LDR immediate gives the offset, LDM gives zero.
      '{ACT_DECODE, 4'd0, 32'h0, 32'hE591_0004, MODE_ARM, 1'b1, 32'h0000_0004, 1'b1},
      '{ACT_DECODE, 4'd0, 32'h0, 32'hE8BD_8000, MODE_ARM, 1'b1, 32'h0000_0000, 1'b1},
      // Never recognized: an undefined Thumb halfword, a data processing word, LDR
      // with a register-specified shift, and MUL in the halfword space.
      '{ACT_DECODE, 4'd0, 32'h0, 32'hFFFF_FFFF, MODE_THUMB, 1'b1, 32'h0, 1'b0},
      '{ACT_DECODE, 4'd0, 32'h0, 32'h0000_0000, MODE_ARM, 1'b1, 32'h0, 1'b0},
      '{ACT_DECODE, 4'd0, 32'h0, 32'hE791_0011, MODE_ARM, 1'b1, 32'h0, 1'b0},
      '{ACT_DECODE, 4'd0, 32'h0, 32'hE000_0090, MODE_ARM, 1'b1, 32'h0, 1'b0},
      // Load registers with boundary values.
      '{ACT_SET_REG, 4'd1, 32'hFFFF_FFFF, 32'h0, MODE_ARM, 1'b0, 32'h0, 1'b0},
      '{ACT_SET_REG, 4'd2, 32'h8000_0000, 32'h0, MODE_ARM, 1'b0, 32'h0, 1'b0},
      '{ACT_SET_REG, 4'd3, 32'h1234_5678, 32'h0, MODE_ARM, 1'b0, 32'h0, 1'b0},
      '{ACT_SET_REG, 4'd13, 32'h0000_1000, 32'h0, MODE_ARM, 1'b0, 32'h0, 1'b0},
      '{ACT_SET_REG, 4'd15, 32'hFFFF_FFFC, 32'h0, MODE_ARM, 1'b0, 32'h0, 1'b0},
      // ARM: immediate down, post-indexed, LSL, the zero-amount LSR, ASR and ROR on a
      // negative operand, LDRH register, LDRSB split immediate, SWP.
      '{ACT_DECODE, 4'd0, 32'h0, 32'hE501_0FFF, MODE_ARM, 1'b0, 32'h0, 1'b0},
      '{ACT_DECODE, 4'd0, 32'h0, 32'hE491_0004, MODE_ARM, 1'b0, 32'h0, 1'b0},
      '{ACT_DECODE, 4'd0, 32'h0, 32'hE791_0082, MODE_ARM, 1'b0, 32'h0, 1'b0},
      '{ACT_DECODE, 4'd0, 32'h0, 32'hE791_0022, MODE_ARM, 1'b0, 32'h0, 1'b0},
      '{ACT_DECODE, 4'd0, 32'h0, 32'hE791_0042, MODE_ARM, 1'b0, 32'h0, 1'b0},
      '{ACT_DECODE, 4'd0, 32'h0, 32'hE791_0062, MODE_ARM, 1'b0, 32'h0, 1'b0},
      '{ACT_DECODE, 4'd0, 32'h0, 32'hE191_00B3, MODE_ARM, 1'b0, 32'h0, 1'b0},
      '{ACT_DECODE, 4'd0, 32'h0, 32'hE1D1_0FDF, MODE_ARM, 1'b0, 32'h0, 1'b0},
      '{ACT_DECODE, 4'd0, 32'h0, 32'hE101_0092, MODE_ARM, 1'b0, 32'h0, 1'b0},
      // Thumb: PC-relative with junk in the upper half, register offset, byte and
      // halfword immediates at their maximum, SP-relative, POP, LDMIA.
      '{ACT_DECODE, 4'd0, 32'h0, 32'hA5A5_48FF, MODE_THUMB, 1'b0, 32'h0, 1'b0},
      '{ACT_DECODE, 4'd0, 32'h0, 32'h0000_5888, MODE_THUMB, 1'b0, 32'h0, 1'b0},
      '{ACT_DECODE, 4'd0, 32'h0, 32'h0000_7FC8, MODE_THUMB, 1'b0, 32'h0, 1'b0},
      '{ACT_DECODE, 4'd0, 32'h0, 32'h0000_8FC8, MODE_THUMB, 1'b0, 32'h0, 1'b0},
      '{ACT_DECODE, 4'd0, 32'h0, 32'h0000_98FF, MODE_THUMB, 1'b0, 32'h0, 1'b0},
      '{ACT_DECODE, 4'd0, 32'h0, 32'h0000_BD00, MODE_THUMB, 1'b0, 32'h0, 1'b0},
      '{ACT_DECODE, 4'd0, 32'h0, 32'h0000_C9FF, MODE_THUMB, 1'b0, 32'h0, 1'b0}
   };

   // Main sequence: reset, directed table, then four random phases with different
   // idling on each side, and finally a drain and the verdict.
   initial begin
      afad_result_type pinned_value;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.action     = ACT_SET_REG;
      req_ch.reg_index  = '0;
      req_ch.reg_value  = '0;
      req_ch.instr_word = '0;
      req_ch.thumb_mode = MODE_ARM;
      rsp_ch.ready      = 1'b1;
      pin_en            = 1'b0;
      pin_value         = '0;
      send_idle_pct     = 0;
      recv_stall_pct    = 0;
      fail_count        = 0;
      n_reg_loads       = 0;
      n_decodes         = 0;
      n_thumb           = 0;
      n_checked         = 0;
      n_recognized      = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         pinned_value.addr = directed_rows[i].pin_addr;
         pinned_value.recognized = directed_rows[i].pin_rec;
         send_request(directed_rows[i].action, directed_rows[i].reg_sel,
                      directed_rows[i].reg_data, directed_rows[i].word,
                      directed_rows[i].thumb, directed_rows[i].pinned, pinned_value);
      end

      // Phase 1: back to back. Phase 2: sender idles half the time. Phase 3: consumer
      // stalls half the time. Phase 4: both sides hold off about a third of the time.
      run_random(PHASE_ITEMS);
      send_idle_pct = 50;
      run_random(PHASE_ITEMS);
      send_idle_pct = 0;
      recv_stall_pct = 50;
      run_random(PHASE_ITEMS);
      send_idle_pct = 30;
      recv_stall_pct = 30;
      run_random(PHASE_ITEMS);

      @(negedge clock);
      req_ch.valid <= 1'b0;

      while (expected_access.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d register loads and %0d decodes (%0d Thumb, %0d ARM).",
               n_reg_loads, n_decodes, n_thumb, n_decodes - n_thumb);
      $display("Compared %0d responses, %0d of them recognized load/store forms.",
               n_checked, n_recognized);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Watchdog: the slowest legal run is a small fraction of this.
   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ arm_thumb_fault_address_decoder.f @@
src/afad_pkg.sv
src/afad_if.sv
src/afad_regfile.sv
src/afad_calc.sv
src/arm_thumb_fault_address_decoder.sv
src/afad_checker.sv
bench/arm_thumb_fault_address_decoder_tb.sv
